// File: src/nesta_pkg.sv
`timescale 1ns / 1ps
package nesta_pkg;

    localparam int STACK_DEPTH  = 8;
    localparam int MAX_SECTIONS = 16;
    localparam int ID_BITS      = 8;
    localparam int SP_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int SI_BITS      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TU_BITS      = $clog2(MAX_SECTIONS + 1);
    localparam int TI_BITS      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_MARKER = 2'd2;

    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_TOTAL   = 2'd1;
    localparam logic [1:0] KIND_STALL   = 2'd2;

    localparam logic [31:0] NO_FRAME = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  event_id;
        logic [63:0] event_time;
        logic [31:0] frame_number;
    } event_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  record_id;
        logic [63:0] total_ticks;
        logic [63:0] self_ticks;
        logic [15:0] hit_count;
        logic        last_record;
    } record_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic track;
        logic push;
        logic pop_read;
        logic scan_first;
        logic scan_step;
        logic commit_end;
        logic dump_first;
        logic dump_step;
        logic emit_section;
        logic emit_total;
        logic emit_stall;
        logic clear_frame;
        logic set_frame;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic       stack_full;
        logic       stack_empty;
        logic       scan_done;
        logic       dump_done;
        logic       new_frame;
        logic       stall_valid;
    } dp_stat_t;

endpackage

// File: src/nesta_datapath.sv
`timescale 1ns / 1ps
module nesta_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  nesta_pkg::event_t  evt,
    input  nesta_pkg::dp_cmd_t cmd,
    output nesta_pkg::dp_stat_t stat,
    output logic               result_valid,
    output nesta_pkg::record_t result
);
    import nesta_pkg::*;

    logic [63:0] stk_start [STACK_DEPTH];
    logic [63:0] stk_child [STACK_DEPTH];
    logic [7:0]  tab_id    [MAX_SECTIONS];
    logic [63:0] tab_total [MAX_SECTIONS];
    logic [63:0] tab_csum  [MAX_SECTIONS];
    logic [15:0] tab_cnt   [MAX_SECTIONS];

    event_t       evt_reg;
    logic [SP_BITS-1:0] depth_reg;
    logic [TU_BITS-1:0] used_reg;
    logic [63:0]  earliest_reg, latest_reg, prev_end_reg;
    logic [31:0]  frame_reg;
    logic [TU_BITS-1:0] idx_reg;
    logic         found_reg;
    logic [63:0]  dur_reg, child_reg;
    logic         result_valid_reg;
    record_t      result_reg;

    logic [7:0]         id_m;
    logic [SI_BITS-1:0] top;
    logic [TI_BITS-1:0] ti;

    assign id_m = evt_reg.event_id & 8'((9'd1 << ID_BITS) - 9'd1);
    assign top  = SI_BITS'(depth_reg - SP_BITS'(1));
    assign ti   = idx_reg[TI_BITS-1:0];

    assign stat.mode        = evt_reg.mode;
    assign stat.stack_full  = (depth_reg >= SP_BITS'(STACK_DEPTH));
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.scan_done   = (idx_reg >= used_reg);
    assign stat.dump_done   = (idx_reg >= used_reg);
    assign stat.new_frame   = (evt_reg.frame_number != frame_reg) && (frame_reg != NO_FRAME);
    assign stat.stall_valid = (prev_end_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            used_reg         <= '0;
            earliest_reg     <= '1;
            latest_reg       <= '0;
            prev_end_reg     <= '0;
            frame_reg        <= NO_FRAME;
            idx_reg          <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit_section | cmd.emit_total | cmd.emit_stall;
            if (cmd.track)
            begin
                if (evt_reg.event_time < earliest_reg) earliest_reg <= evt_reg.event_time;
                if (evt_reg.event_time > latest_reg)   latest_reg   <= evt_reg.event_time;
            end
            if (cmd.push) depth_reg <= depth_reg + SP_BITS'(1);
            if (cmd.scan_first | cmd.dump_first)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (tab_id[ti] == id_m) found_reg <= 1'b1;
                idx_reg <= idx_reg + TU_BITS'(1);
            end
            if (cmd.dump_step) idx_reg <= idx_reg + TU_BITS'(1);
            if (cmd.commit_end)
            begin
                if (!found_reg && used_reg < TU_BITS'(MAX_SECTIONS))
                    used_reg <= used_reg + TU_BITS'(1);
                depth_reg <= depth_reg - SP_BITS'(1);
            end
            // previous end moves only after the stall beat has used it
            if (cmd.clear_frame)
            begin
                depth_reg    <= '0;
                used_reg     <= '0;
                earliest_reg <= '1;
                latest_reg   <= '0;
                prev_end_reg <= latest_reg;
            end
            if (cmd.set_frame) frame_reg <= evt_reg.frame_number;
        end
    end

    // payload and arrays, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load) evt_reg <= evt;
        if (cmd.push)
        begin
            stk_start[depth_reg[SI_BITS-1:0]] <= evt_reg.event_time;
            stk_child[depth_reg[SI_BITS-1:0]] <= '0;
        end
        if (cmd.pop_read)
        begin
            dur_reg   <= evt_reg.event_time - stk_start[top];
            child_reg <= stk_child[top];
        end
        if (cmd.scan_step && tab_id[ti] == id_m)
        begin
            tab_total[ti] <= tab_total[ti] + dur_reg;
            tab_csum[ti]  <= tab_csum[ti] + child_reg;
            if (tab_cnt[ti] != 16'hFFFF) tab_cnt[ti] <= tab_cnt[ti] + 16'd1;
        end
        if (cmd.commit_end)
        begin
            if (!found_reg && used_reg < TU_BITS'(MAX_SECTIONS))
            begin
                tab_id[used_reg[TI_BITS-1:0]]    <= id_m;
                tab_total[used_reg[TI_BITS-1:0]] <= dur_reg;
                tab_csum[used_reg[TI_BITS-1:0]]  <= child_reg;
                tab_cnt[used_reg[TI_BITS-1:0]]   <= 16'd1;
            end
            if (depth_reg > SP_BITS'(1))
                stk_child[SI_BITS'(depth_reg - SP_BITS'(2))] <=
                    stk_child[SI_BITS'(depth_reg - SP_BITS'(2))] + dur_reg;
        end
        if (cmd.emit_section)
        begin
            result_reg.record_kind <= KIND_SECTION;
            result_reg.record_id   <= tab_id[ti];
            result_reg.total_ticks <= tab_total[ti];
            result_reg.self_ticks  <= tab_total[ti] - tab_csum[ti];
            result_reg.hit_count   <= tab_cnt[ti];
            result_reg.last_record <= 1'b0;
        end
        if (cmd.emit_total)
        begin
            result_reg.record_kind <= KIND_TOTAL;
            result_reg.record_id   <= '0;
            result_reg.total_ticks <= latest_reg - earliest_reg;
            result_reg.self_ticks  <= '0;
            result_reg.hit_count   <= '0;
            result_reg.last_record <= (prev_end_reg == '0);
        end
        if (cmd.emit_stall)
        begin
            result_reg.record_kind <= KIND_STALL;
            result_reg.record_id   <= '0;
            result_reg.total_ticks <= earliest_reg - prev_end_reg;
            result_reg.self_ticks  <= '0;
            result_reg.hit_count   <= '0;
            result_reg.last_record <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: src/nesta_ctrl.sv
`timescale 1ns / 1ps
module nesta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  nesta_pkg::dp_stat_t stat,
    output nesta_pkg::dp_cmd_t  cmd,
    output logic                busy
);
    import nesta_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DEC   = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_COMMIT= 7'b0001000,
        ST_DUMP  = 7'b0010000,
        ST_STALL = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                state_next = ST_IDLE;
                case (stat.mode)
                    MODE_BEGIN:
                    begin
                        cmd.track = 1'b1;
                        cmd.push  = !stat.stack_full;
                    end
                    MODE_END:
                    begin
                        cmd.track = 1'b1;
                        if (!stat.stack_empty)
                        begin
                            cmd.pop_read   = 1'b1;
                            cmd.scan_first = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    MODE_MARKER:
                    begin
                        if (stat.new_frame)
                        begin
                            cmd.dump_first = 1'b1;
                            state_next     = ST_DUMP;
                        end
                        else
                            cmd.set_frame = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_SCAN:
            begin
                if (stat.scan_done) state_next = ST_COMMIT;
                else                cmd.scan_step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit_end = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (stat.dump_done)
                begin
                    cmd.emit_total = 1'b1;
                    state_next     = stat.stall_valid ? ST_STALL : ST_DONE;
                end
                else
                begin
                    cmd.emit_section = 1'b1;
                    cmd.dump_step    = 1'b1;
                end
            end
            ST_STALL:
            begin
                cmd.emit_stall = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.clear_frame = 1'b1;
                cmd.set_frame   = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: src/nested_event_self_time_accumulator_unit.sv
`timescale 1ns / 1ps
// begin event: load, then decode and push; end event on an empty stack: load and decode only,
// else load, decode, scan (one table entry per cycle) and commit
// frame marker: load and decode, or with a dump also section beats, total, optional stall beat and done
// a result beat is registered and appears in the cycle after it is formed; outputs cannot be stalled
// async active-low reset empties stack and table and sets no current frame
module nested_event_self_time_accumulator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  nesta_pkg::event_t  item,
    output logic               busy,
    output logic               strobe,
    output nesta_pkg::record_t result
);
    import nesta_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    nesta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    nesta_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (strobe),
        .result       (result)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import nesta_pkg::*;

    class record_board;
        logic [7:0]  stk_id [STACK_DEPTH];
        logic [63:0] stk_start [STACK_DEPTH];
        logic [63:0] stk_child [STACK_DEPTH];
        int          depth;
        logic [7:0]  sec_id [MAX_SECTIONS];
        logic [63:0] sec_total [MAX_SECTIONS];
        logic [63:0] sec_child [MAX_SECTIONS];
        logic [15:0] sec_hits [MAX_SECTIONS];
        int          used;
        logic [63:0] earliest;
        logic [63:0] latest;
        logic [31:0] frame;
        logic [63:0] prev_end;
        record_t     pending[$];
        int          errors;
        int          matched;
        int          dumps;

        function void clear_frame_state();
            depth = 0;
            used = 0;
            earliest = '1;
            latest = '0;
            frame = NO_FRAME;
        endfunction

        function new();
            clear_frame_state();
            prev_end = '0;
            errors = 0;
            matched = 0;
            dumps = 0;
        endfunction

        function void add_record(logic [1:0] kind, logic [7:0] id, logic [63:0] tot,
                                 logic [63:0] slf, logic [15:0] hits);
            record_t r;
            r.record_kind = kind;
            r.record_id = id;
            r.total_ticks = tot;
            r.self_ticks = slf;
            r.hit_count = hits;
            r.last_record = 1'b0;
            pending.insert(pending.size(), r);
        endfunction

        function void note_event(event_t ev);
            logic [7:0]  id;
            logic [63:0] dur;
            logic [63:0] child;
            bit          found;
            id = ev.event_id;
            if (ev.mode == MODE_MARKER) begin
                if (ev.frame_number != frame && frame != NO_FRAME) begin
                    for (int i = 0; i < used; i++)
                        add_record(KIND_SECTION, sec_id[i], sec_total[i],
                                   sec_total[i] - sec_child[i], sec_hits[i]);
                    add_record(KIND_TOTAL, 8'd0, latest - earliest, '0, '0);
                    if (prev_end != 0)
                        add_record(KIND_STALL, 8'd0, earliest - prev_end, '0, '0);
                    pending[pending.size() - 1].last_record = 1'b1;
                    prev_end = latest;
                    dumps++;
                    clear_frame_state();
                end
                frame = ev.frame_number;
                return;
            end
            if (ev.mode != MODE_BEGIN && ev.mode != MODE_END)
                return;
            if (ev.event_time < earliest) earliest = ev.event_time;
            if (ev.event_time > latest) latest = ev.event_time;
            if (ev.mode == MODE_BEGIN) begin
                if (depth < STACK_DEPTH) begin
                    stk_id[depth] = id;
                    stk_start[depth] = ev.event_time;
                    stk_child[depth] = '0;
                    depth++;
                end
                return;
            end
            if (depth == 0)
                return;
            dur = ev.event_time - stk_start[depth - 1];
            child = stk_child[depth - 1];
            found = 0;
            for (int i = 0; i < used; i++) begin
                if (sec_id[i] == id) begin
                    sec_total[i] += dur;
                    sec_child[i] += child;
                    if (sec_hits[i] != 16'hFFFF) sec_hits[i]++;
                    found = 1;
                end
            end
            if (!found && used < MAX_SECTIONS) begin
                sec_id[used] = id;
                sec_total[used] = dur;
                sec_child[used] = child;
                sec_hits[used] = 16'd1;
                used++;
            end
            depth--;
            if (depth > 0)
                stk_child[depth - 1] += dur;
        endfunction

        function void check_record(record_t got);
            record_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected record: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("record mismatch: expected %p, got %p", want, got);
            end
            else
                matched++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    event_t      item;
    logic        busy;
    logic        strobe;
    record_t     result;
    record_board board;
    int          sent;
    logic [63:0] now_ticks;
    logic [7:0]  id_pool [4];

    nested_event_self_time_accumulator_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_record(result);
    end

    // one beat: hold start until the block takes it; start stays high for the next beat
    task automatic send_event(logic [1:0] mode, logic [7:0] id, logic [63:0] t,
                              logic [31:0] fn, bit quiet);
        event_t ev;
        ev.mode = mode;
        ev.event_id = id;
        ev.event_time = t;
        ev.frame_number = fn;
        if (!quiet && $urandom_range(99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        item <= ev;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_event(ev);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [63:0] step_ticks();
        return now_ticks + 64'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 500));
    endfunction

    // random well-nested frame with occasional noise
    task automatic random_frame(logic [31:0] fn, bit quiet);
        int open;
        int n;
        n = $urandom_range(8, 30);
        open = 0;
        for (int k = 0; k < n; k++) begin
            now_ticks = step_ticks();
            case ($urandom_range(0, 19))
                0: send_event(MODE_END, 8'($urandom()), now_ticks, $urandom(), quiet);
                1: send_event(2'd3, 8'($urandom()), {$urandom(), $urandom()},
                              $urandom(), quiet);
                2: send_event(MODE_BEGIN, 8'($urandom()), {$urandom(), $urandom()},
                              $urandom(), quiet);
                default:
                    if (open > 0 && ($urandom_range(0, 1) || open >= STACK_DEPTH + 1)) begin
                        send_event(MODE_END, id_pool[$urandom_range(0, 3)], now_ticks,
                                   $urandom(), quiet);
                        open--;
                    end
                    else begin
                        send_event(MODE_BEGIN, id_pool[$urandom_range(0, 3)], now_ticks,
                                   $urandom(), quiet);
                        open++;
                    end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            send_event(MODE_MARKER, '0, '0, fn - 1, quiet);  // extra marker with a different frame number first
        send_event(MODE_MARKER, '0, '0, fn, quiet);
    endtask

    initial
    begin
        board = new();
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        now_ticks = 64'd1000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frame, first marker, extremes, mismatch, full stack
        send_event(MODE_MARKER, '0, '0, 32'd5, 1);
        send_event(MODE_MARKER, '0, '0, 32'd5, 1);
        send_event(MODE_END, 8'hFF, 64'd7, '0, 1);
        send_event(MODE_MARKER, '0, '0, 32'd6, 1);
        send_event(MODE_BEGIN, 8'hFF, '1, '1, 1);
        send_event(MODE_BEGIN, 8'h00, '0, '0, 1);
        send_event(MODE_END, 8'hAA, 64'd100, '0, 1);
        send_event(MODE_END, 8'h55, 64'd50, '0, 1);
        send_event(2'd3, 8'hFF, '1, '1, 1);
        send_event(MODE_MARKER, '0, '0, 32'hFFFF_FFFE, 1);
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            send_event(MODE_BEGIN, 8'(i), 64'd200 + 64'(i), '0, 1);
        for (int i = 0; i < STACK_DEPTH; i++)
            send_event(MODE_END, 8'(i), 64'd300 + 64'(i * 3), '0, 1);
        send_event(MODE_MARKER, '0, '0, 32'h0000_0000, 1);
        drain();

        // fill the section table past its capacity
        for (int i = 0; i < MAX_SECTIONS + 2; i++) begin
            send_event(MODE_BEGIN, 8'(i * 13), 64'd1000 + 64'(i * 10), '0, 1);
            send_event(MODE_END, 8'(i * 13), 64'd1005 + 64'(i * 10), '0, 1);
        end
        send_event(MODE_MARKER, '0, '0, NO_FRAME, 1);
        send_event(MODE_MARKER, '0, '0, 32'd1, 1);

        // random frames, first stretch with no idling
        for (int f = 0; sent < 345; f++) begin
            for (int j = 0; j < 4; j++)
                id_pool[j] = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'(j * 64 + f);
            random_frame(32'(f + 10) ^ (f[0] ? 32'h8000_0000 : 32'h0), f < 4);
            if (f == 6)
                drain();
        end
        send_event(MODE_MARKER, '0, '0, 32'h1234_5678, 1);
        drain();

        $display("sent %0d events, %0d frame dumps, %0d records matched",
                 sent, board.dumps, board.matched);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d records missing", board.errors,
                     board.pending.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
